// ===== hw/rtl/x86_integer_alu_with_flags_assert.svh =====
// assertion macros shared by the alu checker
// the checker supplies i_clk and i_rst_n
`ifndef X86_INTEGER_ALU_WITH_FLAGS_ASSERT_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_ASSERT_SVH

// consequent holds in the same cycle
`define XALU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the next cycle
`define XALU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/xalu_pkg.sv =====
// shared constants, types and helper functions of the x86 alu
// no dependencies
package xalu_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 5;
    localparam int SIZE_W = 2;
    localparam int CNT_W  = 6;
    localparam int FLAG_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD  = 5'd0;
    localparam logic [CMD_W-1:0] CMD_ADC  = 5'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SBB  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_MUL  = 5'd4;
    localparam logic [CMD_W-1:0] CMD_IMUL = 5'd5;
    localparam logic [CMD_W-1:0] CMD_DIV  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_IDIV = 5'd7;
    localparam logic [CMD_W-1:0] CMD_MOD  = 5'd8;
    localparam logic [CMD_W-1:0] CMD_IMOD = 5'd9;
    localparam logic [CMD_W-1:0] CMD_AND  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_OR   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_XOR  = 5'd12;
    localparam logic [CMD_W-1:0] CMD_SHL  = 5'd13;
    localparam logic [CMD_W-1:0] CMD_SAL  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_SHR  = 5'd15;
    localparam logic [CMD_W-1:0] CMD_SAR  = 5'd16;

    localparam logic [SIZE_W-1:0] SZ_8  = 2'd0;
    localparam logic [SIZE_W-1:0] SZ_16 = 2'd1;

    localparam int CF_IDX = 0;
    localparam int PF_IDX = 1;
    localparam int ZF_IDX = 2;
    localparam int SF_IDX = 3;
    localparam int OF_IDX = 4;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_prep;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic             is_mul;
        logic             is_div;
        logic             div_zero;
        logic [CNT_W-1:0] div_iters;
    } t_dp_stat;

    function automatic logic [DATA_W-1:0] f_mask(input logic [SIZE_W-1:0] size);
        case (size)
            SZ_8:    f_mask = 32'h0000_00ff;
            SZ_16:   f_mask = 32'h0000_ffff;
            default: f_mask = 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [2*DATA_W-1:0] f_mask2(input logic [SIZE_W-1:0] size);
        case (size)
            SZ_8:    f_mask2 = 64'h0000_0000_0000_ffff;
            SZ_16:   f_mask2 = 64'h0000_0000_ffff_ffff;
            default: f_mask2 = 64'hffff_ffff_ffff_ffff;
        endcase
    endfunction

    function automatic logic f_msb(input logic [DATA_W-1:0] v, input logic [SIZE_W-1:0] size);
        case (size)
            SZ_8:    f_msb = v[7];
            SZ_16:   f_msb = v[15];
            default: f_msb = v[31];
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] f_sext(input logic [DATA_W-1:0] v,
                                                 input logic [SIZE_W-1:0] size);
        case (size)
            SZ_8:    f_sext = {{24{v[7]}}, v[7:0]};
            SZ_16:   f_sext = {{16{v[15]}}, v[15:0]};
            default: f_sext = v;
        endcase
    endfunction

    // even number of ones in the low byte
    function automatic logic f_parity(input logic [7:0] b);
        f_parity = ~(^b);
    endfunction

endpackage

// ===== hw/rtl/xalu_ctrl.sv =====
// sequencer of the alu: input and output handshake, divide step count
// depends on xalu_pkg
module xalu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  xalu_pkg::t_dp_stat i_stat,
    output xalu_pkg::t_dp_cmd  o_cmd
);
    import xalu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DPREP = 3'd3;
    localparam logic [2:0] S_DSTEP = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.is_mul) begin
                    n_state = S_MUL;
                end else if (i_stat.is_div && !i_stat.div_zero) begin
                    n_state = S_DPREP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DPREP: begin
                o_cmd.div_prep = 1'b1;
                n_cnt          = i_stat.div_iters;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/xalu_dp.sv =====
// alu datapath: operand capture, multiplier, radix-4 restoring divider,
// result and flag forming, stored flags; depends on xalu_pkg
module xalu_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  xalu_pkg::t_dp_cmd               i_cmd,
    output xalu_pkg::t_dp_stat              o_stat,
    input  logic [xalu_pkg::CMD_W-1:0]      i_command,
    input  logic [xalu_pkg::DATA_W-1:0]     i_source,
    input  logic [xalu_pkg::DATA_W-1:0]     i_dest_low,
    input  logic [xalu_pkg::DATA_W-1:0]     i_dest_high,
    input  logic [xalu_pkg::SIZE_W-1:0]     i_size_code,
    output logic [xalu_pkg::DATA_W-1:0]     o_result_low,
    output logic [xalu_pkg::DATA_W-1:0]     o_result_high,
    output logic [xalu_pkg::FLAG_W-1:0]     o_flags,
    output logic                            o_divide_error
);
    import xalu_pkg::*;

    logic [CMD_W-1:0]    r_cmd;
    logic [DATA_W-1:0]   r_src, r_dlo, r_dhi;
    logic [SIZE_W-1:0]   r_size;
    logic [2*DATA_W-1:0] r_prod;
    logic [2*DATA_W-1:0] r_num;
    logic [DATA_W-1:0]   r_div, r_rem, r_quo;
    logic                r_nneg, r_dneg;
    logic [FLAG_W-1:0]   r_flags, n_flags;
    logic [DATA_W-1:0]   r_res_lo, n_res_lo, r_res_hi, n_res_hi;
    logic                r_derr, n_derr;

    logic [DATA_W-1:0]   mask, s_m, d_m, sx_s, sx_d;
    logic [2*DATA_W-1:0] mask2;
    logic                sgn_div;

    assign mask    = f_mask(r_size);
    assign mask2   = f_mask2(r_size);
    assign s_m     = r_src & mask;
    assign d_m     = r_dlo & mask;
    assign sx_s    = f_sext(s_m, r_size);
    assign sx_d    = f_sext(d_m, r_size);
    assign sgn_div = (r_cmd == CMD_IDIV) || (r_cmd == CMD_IMOD);

    always_comb begin
        o_stat.is_mul   = (r_cmd == CMD_MUL) || (r_cmd == CMD_IMUL);
        o_stat.is_div   = r_cmd inside {[CMD_DIV:CMD_IMOD]};
        o_stat.div_zero = (s_m == '0);
        case (r_size)
            SZ_8:    o_stat.div_iters = CNT_W'(8);
            SZ_16:   o_stat.div_iters = CNT_W'(16);
            default: o_stat.div_iters = CNT_W'(32);
        endcase
    end

    // multiplier, one extra sign bit covers both forms
    logic signed [DATA_W:0]     mul_a, mul_b;
    logic signed [2*DATA_W+1:0] mul_p;
    always_comb begin
        if (r_cmd == CMD_IMUL) begin
            mul_a = $signed({sx_s[DATA_W-1], sx_s});
            mul_b = $signed({sx_d[DATA_W-1], sx_d});
        end else begin
            mul_a = $signed({1'b0, s_m});
            mul_b = $signed({1'b0, d_m});
        end
        mul_p = mul_a * mul_b;
    end

    // divide set-up: magnitudes, dividend left-aligned
    logic [2*DATA_W-1:0] dvd, dvd_abs, dvd_aln;
    logic                dvd_neg, dvs_neg;
    logic [DATA_W-1:0]   dvs_abs;
    always_comb begin
        dvd = {r_dhi, r_dlo} & mask2;
        case (r_size)
            SZ_8:    dvd_neg = sgn_div && dvd[15];
            SZ_16:   dvd_neg = sgn_div && dvd[31];
            default: dvd_neg = sgn_div && dvd[63];
        endcase
        dvd_abs = dvd_neg ? ((~dvd + 64'd1) & mask2) : dvd;
        case (r_size)
            SZ_8:    dvd_aln = dvd_abs << 48;
            SZ_16:   dvd_aln = dvd_abs << 32;
            default: dvd_aln = dvd_abs;
        endcase
        dvs_neg = sgn_div && f_msb(s_m, r_size);
        dvs_abs = dvs_neg ? ((~s_m + 32'd1) & mask) : s_m;
    end

    // two restoring steps per cycle
    logic [DATA_W:0]   t1, t2;
    logic              ge1, ge2;
    logic [DATA_W-1:0] rem1, rem2;
    always_comb begin
        t1   = {r_rem, r_num[2*DATA_W-1]};
        ge1  = (t1 >= {1'b0, r_div});
        rem1 = ge1 ? DATA_W'(t1 - {1'b0, r_div}) : t1[DATA_W-1:0];
        t2   = {rem1, r_num[2*DATA_W-2]};
        ge2  = (t2 >= {1'b0, r_div});
        rem2 = ge2 ? DATA_W'(t2 - {1'b0, r_div}) : t2[DATA_W-1:0];
    end

    // result and flags
    logic [DATA_W:0]   sum, diff;
    logic              cin, cf, of;
    logic [4:0]        cnt;
    logic [2*DATA_W-1:0] shl_t, shr_t;
    logic signed [2*DATA_W-1:0] sar_in, sar_t;
    logic [DATA_W-1:0] quo, rmd, res;
    logic              mul_ov, mul_sf;

    function automatic logic [FLAG_W-1:0] f_res_flags(input logic [DATA_W-1:0] v,
                                                      input logic [SIZE_W-1:0] size,
                                                      input logic c, input logic o);
        f_res_flags = {o, f_msb(v, size), (v == '0), f_parity(v[7:0]), c};
    endfunction

    always_comb begin
        cin    = ((r_cmd == CMD_ADC) || (r_cmd == CMD_SBB)) && r_flags[CF_IDX];
        sum    = {1'b0, d_m} + {1'b0, s_m} + (DATA_W+1)'(cin);
        diff   = {1'b0, d_m} - {1'b0, s_m} - (DATA_W+1)'(cin);
        cnt    = r_src[4:0];
        shl_t  = {{DATA_W{1'b0}}, d_m} << cnt;
        shr_t  = {d_m, {DATA_W{1'b0}}} >> cnt;
        sar_in = $signed({sx_d, {DATA_W{1'b0}}});
        sar_t  = sar_in >>> cnt;
        quo    = (r_nneg != r_dneg) ? (~r_quo + 32'd1) : r_quo;
        rmd    = r_nneg ? (~r_rem + 32'd1) : r_rem;
        case (r_size)
            SZ_8: begin
                mul_sf = r_prod[15];
                mul_ov = (r_cmd == CMD_IMUL) ? (r_prod[15:8] != {8{r_prod[7]}})
                                             : (r_prod[15:8] != '0);
            end
            SZ_16: begin
                mul_sf = r_prod[31];
                mul_ov = (r_cmd == CMD_IMUL) ? (r_prod[31:16] != {16{r_prod[15]}})
                                             : (r_prod[31:16] != '0);
            end
            default: begin
                mul_sf = r_prod[63];
                mul_ov = (r_cmd == CMD_IMUL) ? (r_prod[63:32] != {32{r_prod[31]}})
                                             : (r_prod[63:32] != '0);
            end
        endcase
        n_res_lo = '0;
        n_res_hi = '0;
        n_derr   = 1'b0;
        n_flags  = r_flags;
        res      = '0;
        cf       = 1'b0;
        of       = 1'b0;
        case (r_cmd)
            CMD_ADD, CMD_ADC: begin
                res = sum[DATA_W-1:0] & mask;
                case (r_size)
                    SZ_8:    cf = sum[8];
                    SZ_16:   cf = sum[16];
                    default: cf = sum[32];
                endcase
                of       = f_msb(~(d_m ^ s_m) & (d_m ^ res), r_size);
                n_res_lo = res;
                n_flags  = f_res_flags(res, r_size, cf, of);
            end
            CMD_SUB, CMD_SBB: begin
                res      = diff[DATA_W-1:0] & mask;
                cf       = diff[DATA_W];
                of       = f_msb((d_m ^ s_m) & (d_m ^ res), r_size);
                n_res_lo = res;
                n_flags  = f_res_flags(res, r_size, cf, of);
            end
            CMD_MUL, CMD_IMUL: begin
                n_res_lo = r_prod[DATA_W-1:0];
                n_res_hi = r_prod[2*DATA_W-1:DATA_W];
                n_flags  = {mul_ov, mul_sf, (r_prod == '0), f_parity(r_prod[7:0]), mul_ov};
            end
            CMD_DIV, CMD_IDIV, CMD_MOD, CMD_IMOD: begin
                if (s_m == '0) begin
                    n_derr = 1'b1;
                end else if ((r_cmd == CMD_DIV) || (r_cmd == CMD_IDIV)) begin
                    n_res_lo = quo & mask;
                end else begin
                    n_res_lo = rmd & mask;
                end
            end
            CMD_AND, CMD_OR, CMD_XOR: begin
                if (r_cmd == CMD_AND) begin
                    res = s_m & d_m;
                end else if (r_cmd == CMD_OR) begin
                    res = s_m | d_m;
                end else begin
                    res = s_m ^ d_m;
                end
                n_res_lo = res;
                n_flags  = f_res_flags(res, r_size, 1'b0, 1'b0);
            end
            CMD_SHL, CMD_SAL, CMD_SHR, CMD_SAR: begin
                if (cnt == '0) begin
                    n_res_lo = d_m;
                end else begin
                    if ((r_cmd == CMD_SHL) || (r_cmd == CMD_SAL)) begin
                        res = shl_t[DATA_W-1:0] & mask;
                        // last bit out sits just above the operand
                        case (r_size)
                            SZ_8:    cf = shl_t[8];
                            SZ_16:   cf = shl_t[16];
                            default: cf = shl_t[32];
                        endcase
                        of = f_msb(res, r_size) ^ cf;
                    end else if (r_cmd == CMD_SHR) begin
                        res = shr_t[2*DATA_W-1:DATA_W];
                        cf  = shr_t[DATA_W-1];
                        of  = f_msb(d_m, r_size);
                    end else begin
                        res = sar_t[2*DATA_W-1:DATA_W] & mask;
                        cf  = sar_t[DATA_W-1];
                        of  = 1'b0;
                    end
                    n_res_lo = res;
                    n_flags  = f_res_flags(res, r_size, cf, of);
                end
            end
            default: n_res_lo = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_src  <= i_source;
            r_dlo  <= i_dest_low;
            r_dhi  <= i_dest_high;
            r_size <= i_size_code;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_p[2*DATA_W-1:0] & mask2;
        end
        if (i_cmd.div_prep) begin
            r_num  <= dvd_aln;
            r_div  <= dvs_abs;
            r_rem  <= '0;
            r_quo  <= '0;
            r_nneg <= dvd_neg;
            r_dneg <= dvs_neg;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[2*DATA_W-3:0], 2'b00};
            r_rem <= rem2;
            r_quo <= {r_quo[DATA_W-3:0], ge1, ge2};
        end
        if (i_cmd.finish) begin
            r_res_lo <= n_res_lo;
            r_res_hi <= n_res_hi;
            r_derr   <= n_derr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_cmd.finish) begin
            r_flags <= n_flags;
        end
    end

    assign o_result_low   = r_res_lo;
    assign o_result_high  = r_res_hi;
    assign o_flags        = r_flags;
    assign o_divide_error = r_derr;

endmodule

// ===== hw/rtl/x86_integer_alu_with_flags.sv =====
// channel | direction | handshake             | payload
// in      | to block  | i_in_valid/o_in_stall | command, source, dest_low/high, size_code
// out     | from block| o_out_valid/i_out_stall| result_low/high, five flags, divide_error
//
// one item at a time: load, dispatch and result for add, logic and shift commands;
// multiply adds a product step, divide and modulo a set-up and the radix-4 divider loop
// the result sits in an output register; the next item is taken while it waits
// reset is synchronous, active low, and clears the stored flags
// top level of the x86 alu; depends on xalu_pkg, xalu_ctrl, xalu_dp
module x86_integer_alu_with_flags (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [xalu_pkg::CMD_W-1:0]      i_command,
    input  logic [xalu_pkg::DATA_W-1:0]     i_source,
    input  logic [xalu_pkg::DATA_W-1:0]     i_dest_low,
    input  logic [xalu_pkg::DATA_W-1:0]     i_dest_high,
    input  logic [xalu_pkg::SIZE_W-1:0]     i_size_code,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [xalu_pkg::DATA_W-1:0]     o_result_low,
    output logic [xalu_pkg::DATA_W-1:0]     o_result_high,
    output logic                            o_carry_flag,
    output logic                            o_parity_flag,
    output logic                            o_zero_flag,
    output logic                            o_sign_flag,
    output logic                            o_overflow_flag,
    output logic                            o_divide_error
);
    import xalu_pkg::*;

    t_dp_cmd           dp_cmd;
    t_dp_stat          dp_stat;
    logic [FLAG_W-1:0] flags;

    xalu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    xalu_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_command      (i_command),
        .i_source       (i_source),
        .i_dest_low     (i_dest_low),
        .i_dest_high    (i_dest_high),
        .i_size_code    (i_size_code),
        .o_result_low   (o_result_low),
        .o_result_high  (o_result_high),
        .o_flags        (flags),
        .o_divide_error (o_divide_error)
    );

    assign o_carry_flag    = flags[CF_IDX];
    assign o_parity_flag   = flags[PF_IDX];
    assign o_zero_flag     = flags[ZF_IDX];
    assign o_sign_flag     = flags[SF_IDX];
    assign o_overflow_flag = flags[OF_IDX];

endmodule

// ===== hw/rtl/xalu_checker.sv =====
// port-level checks of the x86 alu, bound to the top level
// depends on x86_integer_alu_with_flags_assert.svh
`include "x86_integer_alu_with_flags_assert.svh"

module xalu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_result_low,
    input logic [31:0] o_result_high,
    input logic        o_divide_error
);

    // a stalled result stays offered
    `XALU_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped")
    // and keeps its value
    `XALU_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall,
                      $stable(o_result_low) && $stable(o_result_high), "result changed")
    // one item in flight: input closes after a transfer
    `XALU_ASSERT_NEXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall, "input left open")
    // a zero divisor returns zero
    `XALU_ASSERT_SAME(a_derr_zero, o_out_valid && o_divide_error,
                      o_result_low == 32'd0 && o_result_high == 32'd0, "divide error value")

endmodule

bind x86_integer_alu_with_flags xalu_checker u_xalu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_low   (o_result_low),
    .o_result_high  (o_result_high),
    .o_divide_error (o_divide_error)
);
